// ===== rtl/cde_pkg.sv =====
// Package for the circular deque engine: sizes, request and status codes,
// and the command and status structs shared by the controller and datapath.
// No dependencies.
package cde_pkg;

  localparam int DEPTH       = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;

  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_TUSER_W = STATUS_W;
  localparam int OUT_FIELD_W = DATA_WIDTH + 2 * SLOT_W + CNT_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Request kinds.
  localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] K_PEEK_FRONT = 3'd4;
  localparam logic [KIND_W-1:0] K_PEEK_BACK  = 3'd5;
  localparam logic [KIND_W-1:0] K_SEARCH     = 3'd6;
  localparam logic [KIND_W-1:0] K_CLEAR      = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // How a finishing request forms its result.
  localparam logic [1:0] FIN_DIRECT = 2'd0;
  localparam logic [1:0] FIN_READ   = 2'd1;
  localparam logic [1:0] FIN_HIT    = 2'd2;
  localparam logic [1:0] FIN_MISS   = 2'd3;

  typedef struct packed {
    logic       load;       // latch the accepted request
    logic       cfg_wr;     // capacity write, clears the queue
    logic       rd_issue;   // read the front or back slot
    logic       srch_next;  // read the next slot of a search walk
    logic       finish;     // commit the request and load the result word
    logic [1:0] fin_sel;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              match;
    logic              last;
    logic              out_free;
  } sts_t;

endpackage

// ===== rtl/cde_ctrl.sv =====
// Controller of the circular deque engine: sequences one request at a time.
// Depends on cde_pkg for the request codes and the command/status structs.
module cde_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          cfg_tvalid,
  output logic          cfg_tready,
  input  cde_pkg::sts_t sts,
  output cde_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_SRCH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.fin_sel = cde_pkg::FIN_DIRECT;
    cmd.cfg_wr  = cfg_tvalid && cfg_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((sts.kind == cde_pkg::K_POP_FRONT || sts.kind == cde_pkg::K_POP_BACK ||
             sts.kind == cde_pkg::K_PEEK_FRONT || sts.kind == cde_pkg::K_PEEK_BACK ||
             sts.kind == cde_pkg::K_SEARCH) && !sts.empty) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = (sts.kind == cde_pkg::K_SEARCH) ? S_SRCH : S_RD;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RD: begin
        cmd.fin_sel = cde_pkg::FIN_READ;
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SRCH: begin
        if (sts.match || sts.last) begin
          cmd.fin_sel = sts.match ? cde_pkg::FIN_HIT : cde_pkg::FIN_MISS;
          if (sts.out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.srch_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/cde_dpath.sv =====
// Datapath of the circular deque engine: ring memory, pointers, count,
// capacity register, search walker and the output word register.
// Depends on cde_pkg for sizes, codes and the command/status structs.
module cde_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cde_pkg::cmd_t                       cmd,
  output cde_pkg::sts_t                       sts,
  input  logic [cde_pkg::KIND_W-1:0]          req_kind,
  input  logic signed [cde_pkg::DATA_WIDTH-1:0] req_data,
  input  logic [cde_pkg::CNT_W-1:0]           cfg_capacity,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cde_pkg::STATUS_W-1:0]        out_status,
  output logic signed [cde_pkg::DATA_WIDTH-1:0] out_read_value,
  output logic [cde_pkg::SLOT_W-1:0]          out_slot_index,
  output logic [cde_pkg::SLOT_W-1:0]          out_logical_index,
  output logic [cde_pkg::CNT_W-1:0]           out_entry_count,
  output logic                                out_is_empty,
  output logic                                out_is_full
);

  localparam int SW = cde_pkg::SLOT_W;
  localparam int CW = cde_pkg::CNT_W;
  localparam int DW = cde_pkg::DATA_WIDTH;

  logic [DW-1:0] mem [cde_pkg::DEPTH];

  logic [cde_pkg::KIND_W-1:0] kind_r;
  logic signed [DW-1:0]       data_r;
  logic [CW-1:0]              cap_r;
  logic [SW-1:0]              head_r, head_nxt;
  logic [SW-1:0]              tail_r, tail_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [SW-1:0]              srch_slot_r;
  logic [SW-1:0]              srch_idx_r;
  logic signed [DW-1:0]       rdata_r;
  logic                       out_valid_r;

  logic [CW-1:0]              cap_eff;
  logic [SW-1:0]              cap_m1;
  logic [SW-1:0]              head_dec, head_inc, tail_dec, tail_inc, srch_inc;
  logic                       full;
  logic                       wr_en, rd_en;
  logic [SW-1:0]              wr_addr, rd_addr;
  logic [cde_pkg::STATUS_W-1:0] st;
  logic signed [DW-1:0]       rv;
  logic [SW-1:0]              slot_hit, pos_hit;

  // Capacity zero acts as one slot; values above the ring size saturate.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_r > CW'(cde_pkg::DEPTH)) begin
      cap_eff = CW'(cde_pkg::DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign cap_m1   = SW'(cap_eff - CW'(1));
  assign head_dec = (head_r == '0) ? cap_m1 : head_r - SW'(1);
  assign tail_dec = (tail_r == '0) ? cap_m1 : tail_r - SW'(1);
  assign head_inc = ({1'b0, head_r} + CW'(1) >= cap_eff) ? '0 : head_r + SW'(1);
  assign tail_inc = ({1'b0, tail_r} + CW'(1) >= cap_eff) ? '0 : tail_r + SW'(1);
  assign srch_inc = ({1'b0, srch_slot_r} + CW'(1) >= cap_eff) ? '0 : srch_slot_r + SW'(1);
  assign full     = (count_r >= cap_eff);

  assign sts.kind     = kind_r;
  assign sts.empty    = (count_r == '0);
  assign sts.match    = (rdata_r == data_r);
  assign sts.last     = (({1'b0, srch_idx_r} + CW'(1)) == count_r);
  assign sts.out_free = !out_valid_r || out_tready;

  assign rd_en   = cmd.rd_issue || cmd.srch_next;
  assign rd_addr = cmd.srch_next ? srch_inc :
                   ((kind_r == cde_pkg::K_POP_BACK || kind_r == cde_pkg::K_PEEK_BACK) ?
                    tail_dec : head_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    st        = cde_pkg::ST_OK;
    rv        = '0;
    slot_hit  = '0;
    pos_hit   = '0;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    if (cmd.finish) begin
      case (cmd.fin_sel)
        cde_pkg::FIN_DIRECT: begin
          case (kind_r)
            cde_pkg::K_PUSH_FRONT: begin
              if (full) begin
                st = cde_pkg::ST_FULL;
              end else begin
                head_nxt  = head_dec;
                wr_en     = 1'b1;
                wr_addr   = head_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            cde_pkg::K_PUSH_BACK: begin
              if (full) begin
                st = cde_pkg::ST_FULL;
              end else begin
                tail_nxt  = tail_inc;
                wr_en     = 1'b1;
                wr_addr   = tail_r;
                count_nxt = count_r + CW'(1);
              end
            end
            cde_pkg::K_SEARCH: begin
              st = cde_pkg::ST_NOTFOUND;
            end
            cde_pkg::K_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
            default: begin
              // Pop or peek that found the queue empty.
              st = cde_pkg::ST_EMPTY;
            end
          endcase
        end
        cde_pkg::FIN_READ: begin
          rv = rdata_r;
          if (kind_r == cde_pkg::K_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
          end else if (kind_r == cde_pkg::K_POP_BACK) begin
            tail_nxt  = tail_dec;
            count_nxt = count_r - CW'(1);
          end
        end
        cde_pkg::FIN_HIT: begin
          slot_hit = srch_slot_r;
          pos_hit  = srch_idx_r;
        end
        default: begin
          st = cde_pkg::ST_NOTFOUND;
        end
      endcase
    end
    if (cmd.cfg_wr) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CW'(cde_pkg::DEPTH);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        cap_r <= cfg_capacity;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, search walker and result word registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= req_kind;
      data_r <= req_data;
    end
    if (cmd.rd_issue) begin
      srch_slot_r <= head_r;
      srch_idx_r  <= '0;
    end else if (cmd.srch_next) begin
      srch_slot_r <= srch_inc;
      srch_idx_r  <= srch_idx_r + SW'(1);
    end
    if (cmd.finish) begin
      out_status        <= st;
      out_read_value    <= rv;
      out_slot_index    <= slot_hit;
      out_logical_index <= pos_hit;
      out_entry_count   <= count_nxt;
      out_is_empty      <= (count_nxt == '0);
      out_is_full       <= (count_nxt >= cap_eff);
    end
  end

  // Ring memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= data_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/circular_deque_engine.sv =====
// Top level of the circular deque engine: stream ports, controller and datapath.
// Depends on cde_pkg, cde_ctrl and cde_dpath.
//
// Usage: a request word enters on the in_ channel (in_tuser holds the request
// kind, in_tdata the value to push or search for). Every request yields
// exactly one result word on the out_ channel: out_tuser holds the status and
// out_tdata the read value, the search match slot and position, the entry
// count and the empty and full flags. The cfg_ channel writes the capacity
// register; a write also clears the queue, and it is taken only between
// requests.
// Sequencing: one request is worked at a time. Push, clear and failed pops or
// peeks finish straight from the execute step, a pop or peek first does one
// ring memory read, and a search walks from the front until a hit or the last
// entry, reading one ring slot per cycle through the single read port.
// The result sits in an output register, so the next request is accepted
// while an earlier result waits; a request that finishes while the receiver
// stalls waits in its last step until the output register frees up.
// Reset: synchronous, active low; the queue comes up empty with capacity 64.
// Ring slots hold no reset value; only stored entries are ever read.
module circular_deque_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request words.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cde_pkg::IN_TDATA_W-1:0]    in_tdata,  // [31:0] data_value
  input  logic [cde_pkg::IN_TUSER_W-1:0]    in_tuser,  // [2:0] kind
  // Result words.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] read_value, [37:32] slot_index, [43:38] logical_index,
  // [50:44] entry_count, [51] is_empty, [52] is_full, [55:53] zero
  output logic [cde_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [cde_pkg::OUT_TUSER_W-1:0]   out_tuser, // [1:0] status
  // Capacity register writes.
  input  logic                              cfg_tvalid,
  output logic                              cfg_tready,
  input  logic [cde_pkg::CNT_W-1:0]         cfg_tdata  // [6:0] capacity
);

  cde_pkg::cmd_t cmd;
  cde_pkg::sts_t sts;

  logic signed [cde_pkg::DATA_WIDTH-1:0] read_value;
  logic [cde_pkg::SLOT_W-1:0]            slot_index;
  logic [cde_pkg::SLOT_W-1:0]            logical_index;
  logic [cde_pkg::CNT_W-1:0]             entry_count;
  logic                                  is_empty;
  logic                                  is_full;

  // The controller only steps through the request; all queue state lives in the
  // datapath.
  cde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cde_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .req_kind          (in_tuser),
    .req_data          (in_tdata[cde_pkg::DATA_WIDTH-1:0]),
    .cfg_capacity      (cfg_tdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_status        (out_tuser),
    .out_read_value    (read_value),
    .out_slot_index    (slot_index),
    .out_logical_index (logical_index),
    .out_entry_count   (entry_count),
    .out_is_empty      (is_empty),
    .out_is_full       (is_full)
  );

  // Result fields packed from the lowest bit up, padded to whole bytes.
  assign out_tdata = {{(cde_pkg::OUT_TDATA_W - cde_pkg::OUT_FIELD_W){1'b0}},
                      is_full, is_empty, entry_count, logical_index, slot_index,
                      read_value};

endmodule

// ===== rtl/cde_checker.sv =====
// Port-level checker for the circular deque engine, bound to the top level.
// Depends on cde_pkg for sizes and status codes.
module cde_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [cde_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [cde_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cde_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [cde_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                            cfg_tvalid,
  input logic                            cfg_tready,
  input logic [cde_pkg::CNT_W-1:0]       cfg_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  // The empty flag agrees with the entry count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[51] == (out_tdata[50:44] == 7'd0)))
    else $error("empty flag disagrees with entry count");

  // A full status comes with the full flag, an empty status with the empty flag
  // and a zero read value.
  a_status_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser != cde_pkg::ST_FULL) || out_tdata[52]) &&
                   ((out_tuser != cde_pkg::ST_EMPTY) ||
                    (out_tdata[51] && (out_tdata[31:0] == 32'd0))))
    else $error("status disagrees with flags");

endmodule

bind circular_deque_engine cde_checker u_cde_checker (.*);

// ===== tb/sv/tb_circular_deque_engine.sv =====
// Self-checking testbench for circular_deque_engine: directed and random request
// streams with random stalls on both sides, checked against an in-bench predictor.
// Depends on cde_pkg and the circular_deque_engine RTL.
`timescale 1ns / 1ps

module tb_circular_deque_engine;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SEGMENTS       = 12;
  localparam int SEG_ITEMS      = 118;

  typedef struct packed {
    logic [cde_pkg::STATUS_W-1:0]   status;
    logic [cde_pkg::DATA_WIDTH-1:0] read_value;
    logic [cde_pkg::SLOT_W-1:0]     slot_index;
    logic [cde_pkg::SLOT_W-1:0]     logical_index;
    logic [cde_pkg::CNT_W-1:0]      entry_count;
    logic                           is_empty;
    logic                           is_full;
  } deque_result_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [cde_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [cde_pkg::IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cde_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [cde_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                            cfg_tvalid = 1'b0;
  logic                            cfg_tready;
  logic [cde_pkg::CNT_W-1:0]       cfg_tdata  = '0;

  // Shadow copy of the deque, updated as each request word is accepted.
  logic [cde_pkg::DATA_WIDTH-1:0] ring_model [cde_pkg::DEPTH];
  logic [cde_pkg::SLOT_W-1:0]     front_slot  = '0;
  logic [cde_pkg::SLOT_W-1:0]     back_slot   = '0;
  logic [cde_pkg::CNT_W-1:0]      entry_total = '0;
  logic [cde_pkg::CNT_W-1:0]      cap_reg     = cde_pkg::CNT_W'(cde_pkg::DEPTH);

  deque_result_t expected_results [$];

  bit steady = 1'b0;  // no stalls on either side while set
  int failures        = 0;
  int requests_sent   = 0;
  int results_seen    = 0;
  int capacity_writes = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int quiet_cycles    = 0;

  circular_deque_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 30);
  endfunction

  // Capacity zero behaves as one slot, anything above the ring size as the full ring.
  function automatic int unsigned effective_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > cde_pkg::DEPTH) return cde_pkg::DEPTH;
    return cap_reg;
  endfunction

  // Applies one request to the shadow deque and returns the result word it must produce.
  function automatic deque_result_t apply_request(logic [cde_pkg::KIND_W-1:0] kind,
                                                  logic [cde_pkg::DATA_WIDTH-1:0] value);
    deque_result_t r;
    int unsigned lim;
    int unsigned s;
    bit found;
    r = '0;
    r.status = cde_pkg::ST_OK;
    lim = effective_capacity();
    found = 1'b0;
    case (kind)
      cde_pkg::K_PUSH_FRONT, cde_pkg::K_PUSH_BACK: begin
        if (entry_total >= lim) begin
          r.status = cde_pkg::ST_FULL;
        end else if (kind == cde_pkg::K_PUSH_FRONT) begin
          front_slot = (front_slot == 0) ? cde_pkg::SLOT_W'(lim - 1) : front_slot - 1'b1;
          ring_model[front_slot] = value;
          entry_total++;
        end else begin
          ring_model[back_slot] = value;
          back_slot = (back_slot + 1 >= lim) ? '0 : back_slot + 1'b1;
          entry_total++;
        end
      end
      cde_pkg::K_POP_FRONT, cde_pkg::K_PEEK_FRONT: begin
        if (entry_total == 0) begin
          r.status = cde_pkg::ST_EMPTY;
        end else begin
          r.read_value = ring_model[front_slot];
          if (kind == cde_pkg::K_POP_FRONT) begin
            front_slot = (front_slot + 1 >= lim) ? '0 : front_slot + 1'b1;
            entry_total--;
          end
        end
      end
      cde_pkg::K_POP_BACK, cde_pkg::K_PEEK_BACK: begin
        if (entry_total == 0) begin
          r.status = cde_pkg::ST_EMPTY;
        end else begin
          // The back entry sits one slot before the rear pointer.
          s = (back_slot == 0) ? lim - 1 : back_slot - 1;
          r.read_value = ring_model[s];
          if (kind == cde_pkg::K_POP_BACK) begin
            back_slot = cde_pkg::SLOT_W'(s);
            entry_total--;
          end
        end
      end
      cde_pkg::K_SEARCH: begin
        r.status = cde_pkg::ST_NOTFOUND;
        for (int i = 0; i < entry_total; i++) begin
          s = (front_slot + i) % lim;
          if (!found && ring_model[s] == value) begin
            found = 1'b1;
            r.status = cde_pkg::ST_OK;
            r.slot_index = cde_pkg::SLOT_W'(s);
            r.logical_index = cde_pkg::SLOT_W'(i);
          end
        end
      end
      default: begin
        front_slot = '0;
        back_slot = '0;
        entry_total = '0;
      end
    endcase
    r.entry_count = entry_total;
    r.is_empty = (entry_total == 0);
    r.is_full = (entry_total >= lim);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
      failures++;
    end
  endfunction

  // Offers one request word, holding it until the block takes it.
  task automatic send_request(input logic [cde_pkg::KIND_W-1:0] kind,
                              input logic [cde_pkg::DATA_WIDTH-1:0] value);
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(apply_request(kind, value));
    requests_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Capacity writes happen only with the block idle; each one empties the deque.
  task automatic write_capacity(input logic [cde_pkg::CNT_W-1:0] value);
    wait_for_results();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    cap_reg = value;
    front_slot = '0;
    back_slot = '0;
    entry_total = '0;
    capacity_writes++;
  endtask

  // Every pop, peek, search and clear request on an empty deque, at the reset capacity.
  task automatic test_empty_queue();
    send_request(cde_pkg::K_POP_FRONT, '0);
    send_request(cde_pkg::K_POP_BACK, '0);
    send_request(cde_pkg::K_PEEK_FRONT, '0);
    send_request(cde_pkg::K_PEEK_BACK, '0);
    send_request(cde_pkg::K_SEARCH, '0);
    send_request(cde_pkg::K_CLEAR, '0);
  endtask

  // Most positive and most negative words at both ends, with search hit and miss.
  task automatic test_value_extremes();
    send_request(cde_pkg::K_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(cde_pkg::K_PUSH_FRONT, 32'h8000_0000);
    send_request(cde_pkg::K_PEEK_FRONT, '0);
    send_request(cde_pkg::K_PEEK_BACK, '0);
    send_request(cde_pkg::K_SEARCH, 32'h7FFF_FFFF);
    send_request(cde_pkg::K_SEARCH, 32'hFFFF_FFFF);
    send_request(cde_pkg::K_POP_BACK, '0);
    send_request(cde_pkg::K_POP_FRONT, '0);
  endtask

  // A zero capacity acts as a single slot; an oversized one saturates at the ring size.
  task automatic test_capacity_limits();
    write_capacity(7'd0);
    send_request(cde_pkg::K_PUSH_FRONT, 32'd5);
    send_request(cde_pkg::K_PUSH_BACK, 32'd6);
    send_request(cde_pkg::K_POP_BACK, '0);
    write_capacity(7'd127);
    send_request(cde_pkg::K_PUSH_BACK, 32'd1);
    send_request(cde_pkg::K_PEEK_BACK, '0);
  endtask

  // Small ring so the rear pointer wraps and peek at the back reads across the wrap.
  task automatic test_ring_wrap();
    write_capacity(7'd3);
    send_request(cde_pkg::K_PUSH_BACK, 32'd1);
    send_request(cde_pkg::K_PUSH_BACK, 32'd2);
    send_request(cde_pkg::K_PUSH_BACK, 32'd3);
    send_request(cde_pkg::K_POP_FRONT, '0);
    send_request(cde_pkg::K_PUSH_BACK, 32'd4);
    send_request(cde_pkg::K_PEEK_BACK, '0);
    send_request(cde_pkg::K_SEARCH, 32'd4);
    send_request(cde_pkg::K_CLEAR, '0);
  endtask

  // Mixed traffic over many capacities: a fill phase, a drain phase, then a balanced mix.
  task automatic test_random_traffic();
    logic [cde_pkg::CNT_W-1:0]      caps [SEGMENTS];
    logic [cde_pkg::CNT_W-1:0]      cap_pick;
    logic [cde_pkg::KIND_W-1:0]     kind;
    logic [cde_pkg::DATA_WIDTH-1:0] value;
    int push_pct;
    int clear_pct;
    int roll;
    caps = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127, 7'd5, 7'd64, 7'd16, 7'd3, 7'd64, 7'd100, 7'd33};
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      cap_pick = (seg == 5 || seg == 11) ? cde_pkg::CNT_W'($urandom_range(127)) : caps[seg];
      write_capacity(cap_pick);
      steady = (seg == 6);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i < 90) begin
          push_pct = 85;
          clear_pct = 0;
        end else if (i < 105) begin
          push_pct = 10;
          clear_pct = 0;
        end else begin
          push_pct = 45;
          clear_pct = 4;
        end
        roll = $urandom_range(99);
        if (roll < clear_pct) begin
          kind = cde_pkg::K_CLEAR;
        end else if (roll < clear_pct + push_pct) begin
          kind = $urandom_range(1) ? cde_pkg::K_PUSH_BACK : cde_pkg::K_PUSH_FRONT;
        end else begin
          case ($urandom_range(4))
            0: kind = cde_pkg::K_POP_FRONT;
            1: kind = cde_pkg::K_POP_BACK;
            2: kind = cde_pkg::K_PEEK_FRONT;
            3: kind = cde_pkg::K_PEEK_BACK;
            default: kind = cde_pkg::K_SEARCH;
          endcase
        end
        // Searches mostly look for something stored; the small pool makes duplicates.
        if (kind == cde_pkg::K_SEARCH && entry_total != 0 && $urandom_range(99) < 60) begin
          value = ring_model[(front_slot + $urandom_range(entry_total - 1))
                             % effective_capacity()];
        end else begin
          roll = $urandom_range(99);
          if (roll < 30) begin
            value = $urandom_range(6) - 3;
          end else if (roll < 40) begin
            case ($urandom_range(3))
              0: value = 32'h7FFF_FFFF;
              1: value = 32'h8000_0000;
              2: value = 32'h0000_0000;
              default: value = 32'hFFFF_FFFF;
            endcase
          end else begin
            value = $urandom();
          end
        end
        send_request(kind, value);
        if ($urandom_range(59) == 0) wait_for_results();
      end
    end
    steady = 1'b0;
  endtask

  // Result side: random back-pressure, and every result word checked against the predictor.
  always @(posedge clk) out_tready <= !take_break();

  always @(posedge clk) begin : check_result
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      status_seen[out_tuser]++;
      if (expected_results.size() == 0) begin
        $error("result word arrived with no request outstanding");
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("read_value", want.read_value, out_tdata[31:0]);
        check_field("slot_index", want.slot_index, out_tdata[37:32]);
        check_field("logical_index", want.logical_index, out_tdata[43:38]);
        check_field("entry_count", want.entry_count, out_tdata[50:44]);
        check_field("is_empty", want.is_empty, out_tdata[51]);
        check_field("is_full", want.is_full, out_tdata[52]);
      end
    end
  end

  // Ends a hung run: counts cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_tvalid && cfg_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_value_extremes();
    test_capacity_limits();
    test_ring_wrap();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Ran %0d requests and checked %0d results across %0d capacity writes.",
             requests_sent, results_seen, capacity_writes);
    $display("Status counts: ok %0d, full %0d, empty %0d, not found %0d.",
             status_seen[cde_pkg::ST_OK], status_seen[cde_pkg::ST_FULL],
             status_seen[cde_pkg::ST_EMPTY], status_seen[cde_pkg::ST_NOTFOUND]);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cde_pkg.sv
rtl/cde_ctrl.sv
rtl/cde_dpath.sv
rtl/circular_deque_engine.sv
rtl/cde_checker.sv
tb/sv/tb_circular_deque_engine.sv
